// ----- hw/rtl/llwa_pkg.sv -----
// Shared types and codes for the least-loaded work assigner.
`default_nettype none

package llwa_pkg;

  localparam int LOAD_W  = 40;
  localparam int WORK_W  = 32;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THREAD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ASSIGN_MODE  = 2'd1;

  localparam logic [1:0] MODE_ONE_TO_ONE  = 2'd0;
  localparam logic [1:0] MODE_ROUND_ROBIN = 2'd1;
  localparam logic [1:0] MODE_BALANCED    = 2'd2;

  localparam logic [CFG_W-1:0] THREAD_COUNT_RST = 5'd1;
  localparam logic [1:0]       ASSIGN_MODE_RST  = MODE_BALANCED;

  typedef struct packed {
    logic [WORK_W-1:0] workload;
    logic              last_group;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        thread_index;
    logic              assigned;
    logic [7:0]        group_index;
    logic [LOAD_W-1:0] thread_load;
    logic              too_many_groups;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM,
    ST_SETUP,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic take;
    logic setup;
    logic rem_start;
    logic rem_step;
    logic scan_issue;
    logic update;
  } ctl_cmd_t;

  typedef struct packed {
    logic dirty;
    logic rem_done;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/llwa_ctrl.sv -----
// Sequencer for the work assigner: steps each group through scan and update, with a remainder pass first when needed.
`default_nettype none

module llwa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire llwa_pkg::dp_stat_t  stat,
  output llwa_pkg::ctl_cmd_t       cmd
);
  import llwa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.dirty ? ST_REM : ST_SCAN;
        end
      end
      ST_REM: begin
        if (stat.rem_done) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take      = in_valid;
        cmd.setup     = in_valid & ~stat.dirty;
        cmd.rem_start = in_valid & stat.dirty;
      end
      ST_REM:    cmd.rem_step   = 1'b1;
      ST_SETUP:  cmd.setup      = 1'b1;
      ST_SCAN:   cmd.scan_issue = 1'b1;
      ST_LAST:   cmd            = '0;
      ST_UPDATE: cmd.update     = stat.out_free;
      default:   cmd            = '0;
    endcase
  end

  // a result is only written once the scan read has drained
  a_update_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> ($past(state_r) == ST_LAST || $past(state_r) == ST_UPDATE))
    else $error("update without finished scan");

  a_update_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> state_r == ST_IDLE)
    else $error("sequencer did not return to idle after update");

  a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (state_r == ST_REM || state_r == ST_SCAN))
    else $error("transfer did not start an item");

endmodule

`default_nettype wire

// ----- hw/rtl/llwa_dp.sv -----
// Datapath: configuration, load memory, group counter, remainder unit, min scan, result register.
`default_nettype none

module llwa_dp #(
  parameter int MAX_THREADS = 16,
  parameter int MAX_GROUPS  = 256,
  parameter int WORK_BITS   = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [llwa_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  wire logic [llwa_pkg::CFG_W-1:0]             cfg_wdata,
  input  wire llwa_pkg::in_item_t                     in_data,
  input  wire llwa_pkg::ctl_cmd_t                     cmd,
  output llwa_pkg::dp_stat_t                          stat,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output llwa_pkg::out_item_t                         out_data
);
  import llwa_pkg::*;

  localparam int TW = $clog2(MAX_THREADS);
  localparam int GW = $clog2(MAX_GROUPS + 1);
  localparam int BW = $clog2(GW);
  localparam int WU = (WORK_BITS < WORK_W) ? WORK_BITS : WORK_W;

  // configuration
  logic [CFG_W-1:0] tc_r;
  logic [1:0]       mode_r;
  logic [CFG_W-1:0] n;

  // item and allocation state
  logic [WU-1:0]    work_r;
  logic             last_r;
  logic [GW-1:0]    g_r;
  logic [TW-1:0]    ptr_r;
  logic             dirty_r;
  logic [TW-1:0]    rem_r;
  logic [BW-1:0]    bc_r;
  logic [TW:0]      rem_t;
  logic [TW-1:0]    rem_nxt;

  // scan
  logic             asg_r;
  logic             over_r;
  logic [TW-1:0]    scan_addr_r;
  logic [TW-1:0]    scan_end_r;
  logic             over_c;
  logic             asg_c;
  logic [TW-1:0]    start_c;
  logic [TW-1:0]    end_c;

  logic [LOAD_W-1:0] mem [MAX_THREADS];
  logic [MAX_THREADS-1:0] vld_r;
  logic [LOAD_W-1:0] rd_data_r;
  logic              rd_ok_r;
  logic [TW-1:0]     rd_idx_r;
  logic              rd_pend_r;
  logic [LOAD_W-1:0] rd_val;
  logic [LOAD_W-1:0] best_r;
  logic [TW-1:0]     best_idx_r;
  logic              first_r;

  logic [LOAD_W:0]   sum;
  logic [LOAD_W-1:0] sat;
  logic              wr_en;

  logic              out_valid_r;
  out_item_t         out_data_r;

  assign n = (tc_r == '0) ? CFG_W'(1)
           : ((32'(tc_r) > MAX_THREADS) ? CFG_W'(MAX_THREADS) : tc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r   <= THREAD_COUNT_RST;
      mode_r <= ASSIGN_MODE_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_IDX_THREAD_COUNT) begin
        tc_r <= cfg_wdata;
      end else if (cfg_idx == CFG_IDX_ASSIGN_MODE) begin
        mode_r <= cfg_wdata[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      work_r <= in_data.workload[WU-1:0];
      last_r <= in_data.last_group;
    end
  end

  // restoring remainder, one counter bit a cycle: rebuilds g mod n after a thread count change
  assign rem_t   = {rem_r, g_r[bc_r]};
  assign rem_nxt = (32'(rem_t) >= 32'(n)) ? TW'(rem_t - (TW+1)'(n)) : TW'(rem_t);

  always_ff @(posedge clk) begin
    if (cmd.rem_start) begin
      rem_r <= '0;
      bc_r  <= BW'(GW - 1);
    end else if (cmd.rem_step) begin
      rem_r <= rem_nxt;
      bc_r  <= bc_r - 1'b1;
    end
  end

  // per-item setup
  always_comb begin
    over_c  = (32'(g_r) >= MAX_GROUPS);
    asg_c   = 1'b1;
    start_c = '0;
    end_c   = '0;
    if (over_c) begin
      asg_c = 1'b0;
    end else begin
      case (mode_r)
        MODE_ONE_TO_ONE: begin
          asg_c = (32'(g_r) < 32'(n));
          if (asg_c) begin
            start_c = TW'(g_r);
            end_c   = TW'(g_r);
          end
        end
        MODE_ROUND_ROBIN: begin
          start_c = ptr_r;
          end_c   = ptr_r;
        end
        default: begin
          start_c = '0;
          end_c   = TW'(n - 1'b1);
        end
      endcase
    end
  end

  assign rd_val = rd_ok_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      asg_r       <= asg_c;
      over_r      <= over_c;
      scan_addr_r <= start_c;
      scan_end_r  <= end_c;
      first_r     <= 1'b1;
    end else begin
      if (cmd.scan_issue) begin
        scan_addr_r <= scan_addr_r + 1'b1;
      end
      if (rd_pend_r) begin
        first_r <= 1'b0;
        // strict compare keeps the lower index on a tie
        if (first_r || rd_val < best_r) begin
          best_r     <= rd_val;
          best_idx_r <= rd_idx_r;
        end
      end
    end
  end

  assign sum   = {1'b0, best_r} + (LOAD_W+1)'(work_r);
  assign sat   = sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];
  assign wr_en = cmd.update & asg_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[best_idx_r] <= sat;
    end
    if (cmd.scan_issue) begin
      rd_data_r <= mem[scan_addr_r];
      rd_ok_r   <= vld_r[scan_addr_r];
      rd_idx_r  <= scan_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_issue;
    end
  end

  // allocation state; a last group clears after its result is formed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      g_r     <= '0;
      ptr_r   <= '0;
      dirty_r <= 1'b0;
    end else begin
      if (cmd.rem_step && bc_r == '0) begin
        ptr_r   <= rem_nxt;
        dirty_r <= 1'b0;
      end
      if (cmd.update) begin
        if (asg_r) begin
          vld_r[best_idx_r] <= 1'b1;
        end
        if (!over_r) begin
          g_r   <= g_r + 1'b1;
          ptr_r <= (32'(ptr_r) + 1 == 32'(n)) ? '0 : ptr_r + 1'b1;
        end
        if (last_r) begin
          vld_r <= '0;
          g_r   <= '0;
          ptr_r <= '0;
        end
      end
      if (cfg_we && cfg_idx == CFG_IDX_THREAD_COUNT) begin
        dirty_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data_r.thread_index    <= asg_r ? 4'(best_idx_r) : 4'd0;
      out_data_r.assigned        <= asg_r;
      out_data_r.group_index     <= 8'(g_r);
      out_data_r.thread_load     <= asg_r ? sat : '0;
      out_data_r.too_many_groups <= over_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.dirty     = dirty_r;
  assign stat.rem_done  = (bc_r == '0);
  assign stat.scan_last = (scan_addr_r == scan_end_r);
  assign stat.out_free  = ~out_valid_r | out_ready;

  a_no_pending_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !rd_pend_r)
    else $error("update while a scan read is outstanding");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !dirty_r |-> (32'(ptr_r) < 32'(n)))
    else $error("rotate pointer beyond thread count");

  a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(g_r) <= MAX_GROUPS)
    else $error("group counter past saturation");

endmodule

`default_nettype wire

// ----- hw/rtl/least_loaded_work_assigner_unit.sv -----
// Top level of the least-loaded work assigner: sequencer plus datapath.
`default_nettype none

// Each work group transfer on in_* yields one result on out_*. In balanced
// mode (n = active thread count) a group scans all n threads through the
// load memory's single read port, one thread per cycle; one-to-one and
// round-robin groups, and any group past the group limit, read a single
// entry. After a write to thread_count the next group first passes through
// the bit-serial remainder unit that rebuilds the rotate position.
// The result register lets a new group be taken while a result waits.
// Configuration must be written through cfg_we/cfg_idx/cfg_wdata only
// while idle; the block itself does not enforce this.
module least_loaded_work_assigner_unit #(
  parameter int MAX_THREADS = 16,
  parameter int MAX_GROUPS  = 256,
  parameter int WORK_BITS   = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [llwa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [llwa_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire llwa_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output llwa_pkg::out_item_t                  out_data
);
  import llwa_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  llwa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  llwa_dp #(
    .MAX_THREADS (MAX_THREADS),
    .MAX_GROUPS  (MAX_GROUPS),
    .WORK_BITS   (WORK_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
